>>> design/npcm_pkg.sv
// Shared types and constants of the nearest palette color match block.
`default_nettype none
package npcm_pkg;

   localparam int PALETTE_DEPTH = 256;
   localparam int FRACTION_BITS = 4;

   localparam int IDX_W      = $clog2(PALETTE_DEPTH);
   localparam int CNT_W      = IDX_W + 1;
   localparam int PCOUNT_W   = 9;
   localparam int CMP_W      = (PCOUNT_W > CNT_W) ? PCOUNT_W : CNT_W;
   localparam int CEN_W      = 8 + FRACTION_BITS;
   localparam int SQ_W       = 2 * CEN_W;
   localparam int SUM_W      = SQ_W + 2;
   localparam int DIST_W     = 26;
   localparam int CENTROID_W = 3 * CEN_W;
   localparam int SUBST_W    = 24;
   localparam int PIXEL_W    = 24;
   localparam int CSR_ADDR_W = 2;

   localparam logic [CSR_ADDR_W-1:0] CSR_PALETTE_COUNT    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MATCH_THRESHOLD  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_THRESHOLD_ENABLE = 2'd2;

   localparam logic REQ_LOAD     = 1'b0;
   localparam logic REQ_CLASSIFY = 1'b1;

   localparam logic [DIST_W-1:0] THRESHOLD_RESET = 26'd25600;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // Tag that travels with one palette entry through the distance pipeline.
   typedef struct packed {
      logic               valid;
      logic [IDX_W-1:0]   index;
      logic [SUBST_W-1:0] subst;
   } entry_tag_type;

endpackage
`default_nettype wire

>>> design/npcm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module npcm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> design/npcm_dist.sv
// Two-stage squared distance unit shared by every palette entry of a search.
`default_nettype none
module npcm_dist (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [npcm_pkg::PIXEL_W-1:0]     pixel,
   input  wire logic [npcm_pkg::CENTROID_W-1:0]  centroid,
   input  wire npcm_pkg::entry_tag_type          tag_in,
   output npcm_pkg::entry_tag_type               tag_out,
   output logic [npcm_pkg::SUM_W-1:0]            dist_out,
   output logic                                  busy
);

   logic [npcm_pkg::SQ_W-1:0]  sq_ff [3];
   logic [npcm_pkg::SQ_W-1:0]  sq_in [3];
   npcm_pkg::entry_tag_type    tag_a_ff, tag_a_in;
   npcm_pkg::entry_tag_type    tag_b_ff, tag_b_in;
   logic [npcm_pkg::SUM_W-1:0] sum_ff, sum_in;

   // Stage A: absolute channel differences and their squares.
   always_comb begin
      logic [npcm_pkg::CEN_W-1:0] p;
      logic [npcm_pkg::CEN_W-1:0] c;
      logic [npcm_pkg::CEN_W-1:0] d;
      for (int ch = 0; ch < 3; ch++) begin
         p = npcm_pkg::CEN_W'(pixel[ch*8 +: 8]) << npcm_pkg::FRACTION_BITS;
         c = centroid[ch*npcm_pkg::CEN_W +: npcm_pkg::CEN_W];
         d = (p >= c) ? (p - c) : (c - p);
         sq_in[ch] = npcm_pkg::SQ_W'(d) * npcm_pkg::SQ_W'(d);
      end
      tag_a_in = tag_in;
   end

   // Stage B: sum of the three squares.
   always_comb begin
      sum_in = npcm_pkg::SUM_W'(sq_ff[0]) + npcm_pkg::SUM_W'(sq_ff[1])
             + npcm_pkg::SUM_W'(sq_ff[2]);
      tag_b_in = tag_a_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_a_ff.valid <= 1'b0;
         tag_b_ff.valid <= 1'b0;
      end else begin
         tag_a_ff.valid <= tag_a_in.valid;
         tag_b_ff.valid <= tag_b_in.valid;
      end
      tag_a_ff.index <= tag_a_in.index;
      tag_a_ff.subst <= tag_a_in.subst;
      tag_b_ff.index <= tag_b_in.index;
      tag_b_ff.subst <= tag_b_in.subst;
      for (int ch = 0; ch < 3; ch++) begin
         sq_ff[ch] <= sq_in[ch];
      end
      sum_ff <= sum_in;
   end

   assign tag_out  = tag_b_ff;
   assign dist_out = sum_ff;
   assign busy     = tag_a_ff.valid;

endmodule
`default_nettype wire

>>> design/nearest_palette_color_match.sv
// Top level of the nearest palette color match block.
// A load transfer writes one palette entry in the cycle it is accepted.
// A classify transfer reads one entry per cycle from the palette RAMs and passes it
// through the shared distance unit, whose three-stage pipeline (RAM read, squares, sum)
// drains before the result register is loaded. A new request is accepted only after
// that result is loaded; an empty palette skips the search.
// Reset is synchronous and active high; the palette RAMs are not cleared by reset.
`default_nettype none
module nearest_palette_color_match (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input stream.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // req_tdata fields from bit 0 up: entry_index[7:0], centroid_red[19:8],
   // centroid_green[31:20], centroid_blue[43:32], subst_red[51:44], subst_green[59:52],
   // subst_blue[67:60], pixel_red[75:68], pixel_green[83:76], pixel_blue[91:84],
   // zero padding[95:92].
   input  wire logic [95:0] req_tdata,
   // req_tuser fields: req_type[0] (0 load palette entry, 1 classify pixel).
   input  wire logic [0:0]  req_tuser,
   // Result stream.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // rsp_tdata fields from bit 0 up: match_index[7:0], matched[8], out_red[16:9],
   // out_green[24:17], out_blue[32:25], best_distance[58:33], zero padding[63:59].
   output logic [63:0]      rsp_tdata,
   // rsp_tuser fields: empty_palette[0].
   output logic [0:0]       rsp_tuser,
   // Configuration write channel.
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [npcm_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  wire logic [npcm_pkg::DIST_W-1:0]         csr_data
);

   // Configuration registers.
   logic [npcm_pkg::PCOUNT_W-1:0] count_ff, count_in;
   logic [npcm_pkg::DIST_W-1:0]   thresh_ff, thresh_in;
   logic                          thr_en_ff, thr_en_in;

   // Sequencer state.
   npcm_pkg::state_type           state_ff, state_in;
   logic [npcm_pkg::IDX_W-1:0]    addr_ff, addr_in;
   logic                          empty_ff, empty_in;
   logic [npcm_pkg::PIXEL_W-1:0]  pixel_ff, pixel_in;

   // Running minimum.
   logic                          first_ff, first_in;
   logic [npcm_pkg::SUM_W-1:0]    best_ff, best_in;
   logic [npcm_pkg::IDX_W-1:0]    best_idx_ff, best_idx_in;
   logic [npcm_pkg::SUBST_W-1:0]  best_sub_ff, best_sub_in;

   // Read tag aligned with the registered RAM outputs.
   logic                          rd_valid_ff, rd_valid_in;
   logic [npcm_pkg::IDX_W-1:0]    rd_idx_ff, rd_idx_in;

   // Result register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [63:0]                   rsp_data_ff, rsp_data_in;
   logic                          rsp_user_ff, rsp_user_in;

   // Sequencer outputs.
   logic issue;
   logic result_load;

   logic                          req_accept;
   logic                          is_load;
   logic                          is_classify;
   logic [npcm_pkg::CMP_W-1:0]    count_eff;
   logic                          last_issue;
   logic                          pipe_busy;

   logic [npcm_pkg::CENTROID_W-1:0] cen_wr;
   logic [npcm_pkg::CENTROID_W-1:0] cen_rd;
   logic [npcm_pkg::SUBST_W-1:0]    sub_rd;

   npcm_pkg::entry_tag_type       dist_tag_in;
   npcm_pkg::entry_tag_type       dist_tag_out;
   logic [npcm_pkg::SUM_W-1:0]    entry_dist;
   logic                          dist_busy;

   assign req_accept  = req_tvalid && req_tready;
   assign is_load     = req_accept && (req_tuser[0] == npcm_pkg::REQ_LOAD);
   assign is_classify = req_accept && (req_tuser[0] == npcm_pkg::REQ_CLASSIFY);
   assign csr_ready   = 1'b1;

   // A palette count above the RAM depth searches the whole RAM.
   always_comb begin
      if (npcm_pkg::CMP_W'(count_ff) > npcm_pkg::CMP_W'(npcm_pkg::PALETTE_DEPTH)) begin
         count_eff = npcm_pkg::CMP_W'(npcm_pkg::PALETTE_DEPTH);
      end else begin
         count_eff = npcm_pkg::CMP_W'(count_ff);
      end
   end

   assign last_issue = (npcm_pkg::CMP_W'(addr_ff) == count_eff - npcm_pkg::CMP_W'(1));
   assign pipe_busy  = rd_valid_ff || dist_busy || dist_tag_out.valid;

   // Each centroid channel keeps its 8 integer and 4 fraction bits.
   assign cen_wr = {npcm_pkg::CEN_W'(req_tdata[43:32]),
                    npcm_pkg::CEN_W'(req_tdata[31:20]),
                    npcm_pkg::CEN_W'(req_tdata[19:8])};

   npcm_ram #(
      .WIDTH (npcm_pkg::CENTROID_W),
      .DEPTH (npcm_pkg::PALETTE_DEPTH)
   ) u_centroid_ram (
      .clock   (clock),
      .wr_en   (is_load),
      .wr_addr (npcm_pkg::IDX_W'(req_tdata[7:0])),
      .wr_data (cen_wr),
      .rd_addr (addr_ff),
      .rd_data (cen_rd)
   );

   npcm_ram #(
      .WIDTH (npcm_pkg::SUBST_W),
      .DEPTH (npcm_pkg::PALETTE_DEPTH)
   ) u_subst_ram (
      .clock   (clock),
      .wr_en   (is_load),
      .wr_addr (npcm_pkg::IDX_W'(req_tdata[7:0])),
      .wr_data (req_tdata[67:44]),
      .rd_addr (addr_ff),
      .rd_data (sub_rd)
   );

   always_comb begin
      dist_tag_in.valid = rd_valid_ff;
      dist_tag_in.index = rd_idx_ff;
      dist_tag_in.subst = sub_rd;
   end

   npcm_dist u_dist (
      .clock    (clock),
      .reset    (reset),
      .pixel    (pixel_ff),
      .centroid (cen_rd),
      .tag_in   (dist_tag_in),
      .tag_out  (dist_tag_out),
      .dist_out (entry_dist),
      .busy     (dist_busy)
   );

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         npcm_pkg::ST_IDLE: begin
            if (is_classify) begin
               if (count_eff == '0) begin
                  state_in = npcm_pkg::ST_FINISH;
               end else begin
                  state_in = npcm_pkg::ST_SEARCH;
               end
            end
         end
         npcm_pkg::ST_SEARCH: begin
            if (last_issue) begin
               state_in = npcm_pkg::ST_DRAIN;
            end
         end
         npcm_pkg::ST_DRAIN: begin
            if (!pipe_busy) begin
               state_in = npcm_pkg::ST_FINISH;
            end
         end
         npcm_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = npcm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = npcm_pkg::ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_tready  = 1'b0;
      issue       = 1'b0;
      result_load = 1'b0;
      case (state_ff)
         npcm_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         npcm_pkg::ST_SEARCH: begin
            issue = 1'b1;
         end
         npcm_pkg::ST_DRAIN: begin
            issue = 1'b0;
         end
         npcm_pkg::ST_FINISH: begin
            result_load = !rsp_valid_ff || rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // Datapath and configuration next values.
   always_comb begin
      logic [npcm_pkg::DIST_W-1:0] final_dist;
      logic                        hit;

      count_in  = count_ff;
      thresh_in = thresh_ff;
      thr_en_in = thr_en_ff;
      if (csr_valid && csr_ready) begin
         case (csr_addr)
            npcm_pkg::CSR_PALETTE_COUNT: begin
               count_in = csr_data[npcm_pkg::PCOUNT_W-1:0];
            end
            npcm_pkg::CSR_MATCH_THRESHOLD: begin
               thresh_in = csr_data;
            end
            npcm_pkg::CSR_THRESHOLD_ENABLE: begin
               thr_en_in = csr_data[0];
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end

      pixel_in = pixel_ff;
      empty_in = empty_ff;
      first_in = first_ff;
      addr_in  = addr_ff;
      if (is_classify) begin
         pixel_in = req_tdata[91:68];
         empty_in = (count_eff == '0);
         first_in = 1'b1;
         addr_in  = '0;
      end else if (issue) begin
         addr_in = addr_ff + npcm_pkg::IDX_W'(1);
      end

      rd_valid_in = issue;
      rd_idx_in   = addr_ff;

      // The first entry always becomes the minimum; later ones only when strictly less,
      // so the lowest index wins a tie.
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      best_sub_in = best_sub_ff;
      if (dist_tag_out.valid && (first_ff || entry_dist < best_ff)) begin
         best_in     = entry_dist;
         best_idx_in = dist_tag_out.index;
         best_sub_in = dist_tag_out.subst;
         first_in    = 1'b0;
      end

      final_dist = npcm_pkg::DIST_W'(best_ff);
      hit        = !thr_en_ff || (final_dist <= thresh_ff);

      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      if (result_load) begin
         rsp_data_in = '0;
         rsp_user_in = empty_ff;
         if (!empty_ff) begin
            rsp_data_in[58:33] = final_dist;
            if (hit) begin
               rsp_data_in[7:0]  = 8'(best_idx_ff);
               rsp_data_in[8]    = 1'b1;
               rsp_data_in[32:9] = best_sub_ff;
            end
         end
      end

      if (result_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         thresh_ff    <= npcm_pkg::THRESHOLD_RESET;
         thr_en_ff    <= 1'b1;
         state_ff     <= npcm_pkg::ST_IDLE;
         addr_ff      <= '0;
         empty_ff     <= 1'b0;
         first_ff     <= 1'b1;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         thresh_ff    <= thresh_in;
         thr_en_ff    <= thr_en_in;
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         empty_ff     <= empty_in;
         first_ff     <= first_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pixel_ff    <= pixel_in;
      rd_idx_ff   <= rd_idx_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      best_sub_ff <= best_sub_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_user_ff;

endmodule
`default_nettype wire
